/* rtl/core/csv_pkg.sv */
`default_nettype none

package csv_pkg;

   // scan depth and derived widths
   localparam int STORE_DEPTH = 64;
   localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
   localparam int ID_W       = 9;
   localparam int VAL_W      = 16;
   localparam int SUM_W      = VAL_W + CNT_W;
   localparam int STEP_W     = $clog2(SUM_W);

   // configuration register map
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_VALID_FRAMES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_FRAMES  = 1'd1;
   localparam logic [CSR_DAT_W-1:0] FRAMES_RESET     = 7'd64;

   typedef struct packed {
      logic                    detected;
      logic [ID_W-1:0]         cell_id;
      logic                    cp_normal;
      logic                    fdd;
      logic [VAL_W-1:0]        peak;
      logic [VAL_W-1:0]        psr;
      logic signed [VAL_W-1:0] cfo_hz;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [ID_W-1:0]         best_cell_id;
      logic                    best_cp_normal;
      logic                    best_fdd;
      logic [VAL_W-1:0]        peak_mean;
      logic [VAL_W-1:0]        last_psr;
      logic signed [VAL_W-1:0] last_cfo_hz;
      logic [6:0]              mode_count;
      logic [6:0]              detect_count;
   } rsp_type;

   // one distinct cell id with its tallies
   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] ncp;
      logic [CNT_W-1:0] nfdd;
   } cell_data_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic            clear;
      logic            shift;
      logic            update;
      logic [ID_W-1:0] id;
      logic            cp;
      logic            fdd;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VOTE,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/csv_cell.sv */
`default_nettype none

module csv_cell import csv_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          load,
   input  wire cell_data_type nb_data,
   output cell_data_type      data,
   output logic               hit
);

   cell_data_type data_ff, data_in;

   // this cell already holds the broadcast id
   assign hit  = data_ff.valid && (data_ff.id == ctrl.id);
   assign data = data_ff;

   // clear, shift toward the head, tally or take a new id
   always_comb begin
      data_in = data_ff;
      if (ctrl.clear) begin
         data_in.valid = 1'b0;
      end else if (ctrl.shift) begin
         data_in = nb_data;
      end else if (ctrl.update) begin
         if (hit) begin
            data_in.cnt  = data_ff.cnt + CNT_W'(1);
            data_in.ncp  = data_ff.ncp + CNT_W'(ctrl.cp);
            data_in.nfdd = data_ff.nfdd + CNT_W'(ctrl.fdd);
         end else if (load) begin
            data_in.valid = 1'b1;
            data_in.id    = ctrl.id;
            data_in.cnt   = CNT_W'(1);
            data_in.ncp   = CNT_W'(ctrl.cp);
            data_in.nfdd  = CNT_W'(ctrl.fdd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/csv_div.sv */
`default_nettype none

module csv_div import csv_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  busy,
   output logic [SUM_W-1:0]      quotient
);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              qbit;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // one restoring step per cycle, dividend bits shift out as quotient shifts in
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign qbit  = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], qbit};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

/* rtl/core/cell_search_vote.sv */
`default_nettype none

// Plurality vote over one cell-search scan. Each accepted item is one frame's
// synchronizer report. Detected frames are tallied in a row of STORE_DEPTH
// cells, one per distinct cell id in order of first appearance. The scan ends
// after scan_frames frames (capped at STORE_DEPTH) or valid_frames detections;
// the block then shifts the cell row past a running best one cell per cycle
// (ties keep the earliest id) while a bit-serial divider forms the mean peak,
// and emits one decision item. After an item that ends a scan, the next item
// is held off until the decision has been formed and taken from the output;
// other items do not hold off the next one.
// Input is stalled while a decision is being formed or waits on the output.
module cell_search_vote import csv_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [CSR_DAT_W-1:0] valid_frames_ff, scan_frames_ff;
   logic [CNT_W-1:0]     frames_ff, frames_in;
   logic [CNT_W-1:0]     dets_ff, dets_in;
   logic [CNT_W-1:0]     distinct_ff, distinct_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [VAL_W-1:0]     psr_ff, psr_in;
   logic [VAL_W-1:0]     cfo_ff, cfo_in;
   logic [CNT_W-1:0]     vote_ff, vote_in;
   cell_data_type        best_ff, best_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 store;
   logic                 scan_end;
   logic                 vote_done;
   logic                 div_start;
   logic                 div_busy;
   logic [SUM_W-1:0]     quotient;
   logic [CSR_DAT_W-1:0] limit;
   logic                 any_hit;

   cell_ctrl_type        ctrl;
   cell_data_type        cells [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] hits;
   logic [STORE_DEPTH-1:0] loads;

   assign accept = req_valid && !req_stall;
   assign store  = accept && req_data.detected && (dets_ff < CNT_W'(STORE_DEPTH));
   assign limit  = (scan_frames_ff > CSR_DAT_W'(STORE_DEPTH)) ?
                   CSR_DAT_W'(STORE_DEPTH) : scan_frames_ff;

   // stop test after the frame is counted
   assign frames_in = accept ? frames_ff + CNT_W'(1) : frames_ff;
   assign dets_in   = store ? dets_ff + CNT_W'(1) : dets_ff;
   assign scan_end  = accept && ((CSR_DAT_W'(frames_in) >= limit) ||
                                 (CSR_DAT_W'(dets_in) >= valid_frames_ff));

   assign vote_done = (state_ff == ST_VOTE) && (vote_ff == CNT_W'(STORE_DEPTH))
                      && !div_busy;
   assign div_start = (state_ff == ST_VOTE) && (vote_ff == '0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_frames_ff <= FRAMES_RESET;
         scan_frames_ff  <= FRAMES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_VALID_FRAMES: valid_frames_ff <= csr_wdata;
            REG_SCAN_FRAMES:  scan_frames_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (scan_end) state_in = ST_VOTE;
         ST_VOTE:   if (vote_done) state_in = ST_RESULT;
         ST_RESULT: if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_VOTE:   req_stall = 1'b1;
         ST_RESULT: rsp_valid = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   // broadcast to the cell row
   always_comb begin
      ctrl.clear  = vote_done;
      ctrl.shift  = (state_ff == ST_VOTE) && (vote_ff != CNT_W'(STORE_DEPTH));
      ctrl.update = store;
      ctrl.id     = req_data.cell_id;
      ctrl.cp     = req_data.cp_normal;
      ctrl.fdd    = req_data.fdd;
   end

   assign any_hit = |hits;

   // new id goes to the first free cell
   genvar gi;
   generate
      for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
         cell_data_type nb;
         assign loads[gi] = !any_hit && (distinct_ff == CNT_W'(gi));
         if (gi == STORE_DEPTH - 1) begin : g_tail
            assign nb = '0;
         end else begin : g_mid
            assign nb = cells[gi+1];
         end
         csv_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .load    (loads[gi]),
            .nb_data (nb),
            .data    (cells[gi]),
            .hit     (hits[gi])
         );
      end
   endgenerate

   csv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (dets_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // scan accumulators, cleared once the decision is formed
   always_comb begin
      distinct_in = distinct_ff;
      sum_in      = sum_ff;
      psr_in      = psr_ff;
      cfo_in      = cfo_ff;
      if (store && !any_hit) begin
         distinct_in = distinct_ff + CNT_W'(1);
      end
      if (store) begin
         sum_in = sum_ff + SUM_W'(req_data.peak);
         psr_in = req_data.psr;
         cfo_in = req_data.cfo_hz;
      end
   end

   // running best over cells leaving the head, strict compare keeps earliest
   always_comb begin
      best_in = best_ff;
      vote_in = vote_ff;
      if (scan_end) begin
         best_in.cnt = '0;
         vote_in     = '0;
      end else if (ctrl.shift) begin
         vote_in = vote_ff + CNT_W'(1);
         if (cells[0].valid && (cells[0].cnt > best_ff.cnt)) begin
            best_in = cells[0];
         end
      end
   end

   // decision item
   always_comb begin
      rsp_in = rsp_ff;
      if (vote_done) begin
         rsp_in = '0;
         if (dets_ff != '0) begin
            rsp_in.found          = 1'b1;
            rsp_in.best_cell_id   = best_ff.id;
            rsp_in.best_cp_normal = best_ff.ncp > (best_ff.cnt >> 1);
            rsp_in.best_fdd       = best_ff.nfdd > (best_ff.cnt >> 1);
            rsp_in.peak_mean      = quotient[VAL_W-1:0];
            rsp_in.last_psr       = psr_ff;
            rsp_in.last_cfo_hz    = cfo_ff;
            rsp_in.mode_count     = 7'(best_ff.cnt);
            rsp_in.detect_count   = 7'(dets_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || vote_done) begin
         state_ff    <= reset ? ST_IDLE : state_in;
         frames_ff   <= '0;
         dets_ff     <= '0;
         distinct_ff <= '0;
         sum_ff      <= '0;
         psr_ff      <= '0;
         cfo_ff      <= '0;
         vote_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         frames_ff   <= frames_in;
         dets_ff     <= dets_in;
         distinct_ff <= distinct_in;
         sum_ff      <= sum_in;
         psr_ff      <= psr_in;
         cfo_ff      <= cfo_in;
         vote_ff     <= vote_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
